// ----- hw/rtl/uts_pkg.sv -----
// uts_pkg: shared types, constants and helper functions of the utf-8 text sanitizer
// no dependencies
`timescale 1ns / 1ps

package uts_pkg;

	localparam int unsigned MAX_SEQUENCE_DEF = 4;
	localparam int unsigned QUEUE_DEPTH_DEF  = 4;
	localparam int unsigned LEN_W            = 3;

	localparam logic [7:0] ASCII_DEL   = 8'h7F;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_TAB   = 8'h09;
	localparam logic [7:0] ASCII_LF    = 8'h0A;
	localparam logic [7:0] ASCII_CR    = 8'h0D;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_CODE  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_CODE  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK  = 8'hF8;
	localparam logic [7:0] LEAD4_CODE  = 8'hF0;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_CODE   = 8'h80;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_present;
		logic       run_last;
		logic       text_end;
	} out_item_t;

	function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
		logic [LEN_W-1:0] len;
		len = '0;
		if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			len = LEN_W'(2);
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			len = LEN_W'(3);
		end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
			len = LEN_W'(4);
		end
		return len;
	endfunction

	function automatic logic is_clean_ascii(input logic [7:0] b);
		return ((b >= ASCII_SPACE) && (b < ASCII_DEL)) || (b == ASCII_TAB) ||
			(b == ASCII_LF) || (b == ASCII_CR);
	endfunction

endpackage

// ----- hw/rtl/uts_stream_if.sv -----
// uts_stream_if: valid/ready channel carrying one payload per transaction
// payload type is a parameter, types come from uts_pkg at the instance
`timescale 1ns / 1ps

interface uts_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/uts_front.sv -----
// uts_front: classifies each accepted byte, holds pending multi-byte sequences
// and builds one job of up to MAX_SEQUENCE result bytes; depends on uts_pkg
`timescale 1ns / 1ps

module uts_front #(
	parameter int unsigned MAX_SEQUENCE = uts_pkg::MAX_SEQUENCE_DEF,
	localparam int unsigned HC_W  = $clog2(MAX_SEQUENCE),
	localparam int unsigned CNT_W = $clog2(MAX_SEQUENCE + 1),
	localparam int unsigned JOB_W = MAX_SEQUENCE * 8 + CNT_W + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  uts_pkg::in_item_t item,
	output logic              push,
	output logic [JOB_W-1:0]  job
);
	import uts_pkg::*;

	typedef struct packed {
		logic [MAX_SEQUENCE-1:0][7:0] bytes;
		logic [CNT_W-1:0]             n;
		logic                         present;
		logic                         text_end;
	} job_t;

	logic [MAX_SEQUENCE-2:0][7:0] held_q, held_d;
	logic [LEN_W-1:0]             exp_q, exp_d;
	logic [HC_W-1:0]              cnt_q, cnt_d;
	job_t                         job_c;
	logic                         done;
	logic                         cont;
	logic [LEN_W-1:0]             len;
	logic [7:0]                   b;

	always_comb begin
		b       = item.in_byte;
		cont    = (b & CONT_MASK) == CONT_CODE;
		len     = lead_length(b);
		held_d  = held_q;
		exp_d   = exp_q;
		cnt_d   = cnt_q;
		done    = 1'b0;
		job_c   = '0;
		job_c.present  = 1'b1;
		job_c.text_end = item.end_of_text;

		if (exp_q != '0) begin
			exp_d = '0;
			cnt_d = '0;
			if (cont) begin
				done = 1'b1;
				if ((LEN_W'(cnt_q) + LEN_W'(1)) >= exp_q) begin
					for (int k = 0; k < MAX_SEQUENCE - 1; k++) begin
						job_c.bytes[k] = held_q[k];
					end
					for (int k = 0; k < MAX_SEQUENCE; k++) begin
						if (HC_W'(k) == cnt_q) begin
							job_c.bytes[k] = b;
						end
					end
					job_c.n = CNT_W'(cnt_q) + CNT_W'(1);
				end else if (cnt_q < HC_W'(MAX_SEQUENCE - 1)) begin
					for (int k = 0; k < MAX_SEQUENCE - 1; k++) begin
						if (HC_W'(k) == cnt_q) begin
							held_d[k] = b;
						end
					end
					cnt_d = cnt_q + HC_W'(1);
					exp_d = exp_q;
				end
			end
		end

		if (!done) begin
			if (b <= ASCII_DEL) begin
				if (is_clean_ascii(b)) begin
					job_c.bytes[0] = b;
					job_c.n        = CNT_W'(1);
				end
			end else if ((len != '0) && (len <= LEN_W'(MAX_SEQUENCE)) && !item.end_of_text) begin
				held_d[0] = b;
				cnt_d     = HC_W'(1);
				exp_d     = len;
			end
		end

		if (item.end_of_text) begin
			exp_d = '0;
			cnt_d = '0;
			if (job_c.n == '0) begin
				job_c.n        = CNT_W'(1);
				job_c.present  = 1'b0;
				job_c.bytes[0] = 8'h00;
			end
		end
	end

	assign push = fire && (job_c.n != '0);
	assign job  = job_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			cnt_q <= '0;
		end else if (fire) begin
			exp_q <= exp_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			held_q <= held_d;
		end
	end
endmodule

// ----- hw/rtl/uts_queue.sv -----
// uts_queue: small job queue between front and back parts
// register-based circular buffer, no package dependency
`timescale 1ns / 1ps

module uts_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             not_empty,
	output logic             not_full
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign not_empty = count_q != '0;
	assign not_full  = count_q != CW'(DEPTH);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ----- hw/rtl/uts_back.sv -----
// uts_back: walks the head job into a registered output, one result per cycle
// while the sink is ready; depends on uts_pkg for the result type
`timescale 1ns / 1ps

module uts_back #(
	parameter int unsigned MAX_SEQUENCE = uts_pkg::MAX_SEQUENCE_DEF,
	localparam int unsigned HC_W  = $clog2(MAX_SEQUENCE),
	localparam int unsigned CNT_W = $clog2(MAX_SEQUENCE + 1),
	localparam int unsigned JOB_W = MAX_SEQUENCE * 8 + CNT_W + 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [JOB_W-1:0]   head,
	input  logic               not_empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output uts_pkg::out_item_t out_item
);
	import uts_pkg::*;

	typedef struct packed {
		logic [MAX_SEQUENCE-1:0][7:0] bytes;
		logic [CNT_W-1:0]             n;
		logic                         present;
		logic                         text_end;
	} job_t;

	job_t            job_c;
	logic [HC_W-1:0] idx_q;
	logic            valid_q;
	out_item_t       item_q;
	out_item_t       item_c;
	logic            load;
	logic            last_c;

	always_comb begin
		job_c  = head;
		last_c = (CNT_W'(idx_q) + CNT_W'(1)) == job_c.n;
		item_c = '0;
		for (int k = 0; k < MAX_SEQUENCE; k++) begin
			if (HC_W'(k) == idx_q) begin
				item_c.out_byte = job_c.bytes[k];
			end
		end
		item_c.byte_present = job_c.present;
		item_c.run_last     = last_c;
		item_c.text_end     = last_c && job_c.text_end;
	end

	assign load      = not_empty && (!valid_q || out_ready);
	assign pop       = load && last_c;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_c ? '0 : idx_q + HC_W'(1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_c;
		end
	end
endmodule

// ----- hw/rtl/utf8_text_sanitizer_core.sv -----
// utf8_text_sanitizer_core: top level of the utf-8 text sanitizer
// uses uts_pkg, uts_stream_if, uts_front, uts_queue, uts_back
//
//   channel  modport  payload              per transaction
//   raw      sink     uts_pkg::in_item_t   one raw text byte and end flag
//   clean    source   uts_pkg::out_item_t  one kept byte or a bare end marker
//
// a raw byte is taken every cycle while the job queue has room; its results
// leave one per cycle from the back part while the sink is ready;
// the output register and QUEUE_DEPTH jobs buffer a stalled sink
// arst_n clears pending-sequence state, queue pointers and the output valid
`timescale 1ns / 1ps

module utf8_text_sanitizer_core #(
	parameter int unsigned MAX_SEQUENCE = uts_pkg::MAX_SEQUENCE_DEF,
	parameter int unsigned QUEUE_DEPTH  = uts_pkg::QUEUE_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	uts_stream_if.sink   raw,
	uts_stream_if.source clean
);
	import uts_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SEQUENCE + 1);
	localparam int unsigned JOB_W = MAX_SEQUENCE * 8 + CNT_W + 2;

	logic             fire;
	logic             push;
	logic [JOB_W-1:0] job;
	logic [JOB_W-1:0] head;
	logic             pop;
	logic             not_empty;
	logic             not_full;
	in_item_t         in_item;
	out_item_t        out_item;

	assign in_item   = raw.payload;
	assign raw.ready = not_full;
	assign fire      = raw.valid && not_full;

	uts_front #(
		.MAX_SEQUENCE(MAX_SEQUENCE)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (in_item),
		.push  (push),
		.job   (job)
	);

	uts_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(job),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty),
		.not_full (not_full)
	);

	uts_back #(
		.MAX_SEQUENCE(MAX_SEQUENCE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.not_empty(not_empty),
		.pop      (pop),
		.out_valid(clean.valid),
		.out_ready(clean.ready),
		.out_item (out_item)
	);

	assign clean.payload = out_item;
endmodule
